/* design/chatan_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chatan_pkg: shared types and constants for the compass heading block
// Widths, fixed-point constants, the CORDIC stage record and the arctangent
// table used by the micro-rotation cells of the chain.
// ----------------------------------------------------------------------------
package chatan_pkg;

  localparam int IN_W              = 16;
  localparam int XW                = 26;
  localparam int ZW                = 28;
  localparam int HW                = 18;
  localparam int RAD_W             = 16;
  localparam int DEG_W             = 15;
  localparam int DECL_W            = 16;
  localparam int PRE_SHIFT         = 8;
  localparam int ANG_TABLE_LEN     = 24;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int HALF_PI_Q24       = 26353589;
  localparam int TWO_PI_Q13        = 51472;
  localparam int DECL_RESET        = 3957;
  localparam int DEG_MUL           = 469367;
  localparam int DEG_SHIFT         = 20;
  localparam int ROUND_BIAS        = 1024;
  localparam int ROUND_SHIFT       = 11;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_q24(input int idx);
    case (idx)
      0:       return ZW'(13176795);
      1:       return ZW'(7778716);
      2:       return ZW'(4110060);
      3:       return ZW'(2086331);
      4:       return ZW'(1047214);
      5:       return ZW'(524117);
      6:       return ZW'(262123);
      7:       return ZW'(131069);
      8:       return ZW'(65536);
      9:       return ZW'(32768);
      10:      return ZW'(16384);
      11:      return ZW'(8192);
      12:      return ZW'(4096);
      13:      return ZW'(2048);
      14:      return ZW'(1024);
      15:      return ZW'(512);
      16:      return ZW'(256);
      17:      return ZW'(128);
      18:      return ZW'(64);
      19:      return ZW'(32);
      20:      return ZW'(16);
      21:      return ZW'(8);
      22:      return ZW'(4);
      23:      return ZW'(2);
      default: return '0;
    endcase
  endfunction

endpackage
`default_nettype wire

/* design/chatan_prerot.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chatan_prerot: quadrant pre-rotation cell
// Scales the sample, turns left-half-plane vectors by a quarter turn and
// seeds the angle accumulator; flags the zero vector.
// ----------------------------------------------------------------------------
module chatan_prerot (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic signed [chatan_pkg::IN_W-1:0] mag_x,
  input  wire logic signed [chatan_pkg::IN_W-1:0] mag_y,
  input  wire logic                              up_valid,
  output logic                                   up_ready,
  output chatan_pkg::cordic_t                    dn_data,
  output logic                                   dn_valid,
  input  wire logic                              dn_ready
);
  import chatan_pkg::*;

  localparam logic signed [ZW-1:0] HALF_PI = ZW'(HALF_PI_Q24);

  logic                 valid_r;
  cordic_t              data_r;
  cordic_t              data_nxt;
  logic signed [XW-1:0] xe;
  logic signed [XW-1:0] ye;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    xe            = XW'(mag_x) <<< PRE_SHIFT;
    ye            = XW'(mag_y) <<< PRE_SHIFT;
    data_nxt.x    = xe;
    data_nxt.y    = ye;
    data_nxt.z    = '0;
    data_nxt.zero = (mag_x == '0) && (mag_y == '0);
    if (xe < 0) begin
      if (ye >= 0) begin
        data_nxt.x = ye;
        data_nxt.y = -xe;
        data_nxt.z = HALF_PI;
      end else begin
        data_nxt.x = -ye;
        data_nxt.y = xe;
        data_nxt.z = -HALF_PI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_data  = data_r;
  assign dn_valid = valid_r;

endmodule
`default_nettype wire

/* design/chatan_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chatan_cell: one CORDIC vectoring micro-rotation
// Rotates toward the x axis by atan(2^-STAGE) and updates the angle
// accumulator; holds its result until the next cell takes it.
// ----------------------------------------------------------------------------
module chatan_cell #(
  parameter int STAGE = 0
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire chatan_pkg::cordic_t up_data,
  input  wire logic                up_valid,
  output logic                     up_ready,
  output chatan_pkg::cordic_t      dn_data,
  output logic                     dn_valid,
  input  wire logic                dn_ready
);
  import chatan_pkg::*;

  logic                 valid_r;
  cordic_t              data_r;
  cordic_t              data_nxt;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    xs       = up_data.x >>> STAGE;
    ys       = up_data.y >>> STAGE;
    data_nxt = up_data;
    if (up_data.y > 0) begin
      data_nxt.x = up_data.x + ys;
      data_nxt.y = up_data.y - xs;
      data_nxt.z = up_data.z + atan_q24(STAGE);
    end else begin
      data_nxt.x = up_data.x - ys;
      data_nxt.y = up_data.y + xs;
      data_nxt.z = up_data.z - atan_q24(STAGE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_data  = data_r;
  assign dn_valid = valid_r;

endmodule
`default_nettype wire

/* design/chatan_wrap.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chatan_wrap: angle rounding, declination and wrap cells
// Rounds the accumulator to Q3.13, adds the declination, then wraps the sum
// into zero up to below two pi.
// ----------------------------------------------------------------------------
module chatan_wrap (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire chatan_pkg::cordic_t                 up_data,
  input  wire logic                                up_valid,
  output logic                                     up_ready,
  input  wire logic signed [chatan_pkg::DECL_W-1:0] decl,
  output logic [chatan_pkg::RAD_W-1:0]             dn_rad,
  output logic                                     dn_valid,
  input  wire logic                                dn_ready
);
  import chatan_pkg::*;

  localparam logic signed [HW-1:0] TWO_PI = HW'(TWO_PI_Q13);

  logic                 a_valid_r;
  logic                 b_valid_r;
  logic                 b_ready;
  logic signed [ZW-1:0] raw_full;
  logic signed [HW-1:0] h_r;
  logic signed [HW-1:0] h_nxt;
  logic signed [HW-1:0] t;
  logic [RAD_W-1:0]     rad_r;
  logic [RAD_W-1:0]     rad_nxt;

  assign up_ready = !a_valid_r || b_ready;
  assign b_ready  = !b_valid_r || dn_ready;

  always_comb begin
    raw_full = (up_data.z + ZW'(ROUND_BIAS)) >>> ROUND_SHIFT;
    if (up_data.zero) begin
      raw_full = '0;
    end
    h_nxt = HW'(raw_full) + HW'(decl);
  end

  always_comb begin
    t = h_r;
    if (t < 0) begin
      t = t + TWO_PI;
    end
    if (t < 0) begin
      t = t + TWO_PI;
    end
    if (t >= TWO_PI) begin
      t = t - TWO_PI;
    end
    if (t >= TWO_PI) begin
      t = t - TWO_PI;
    end
    rad_nxt = RAD_W'(t);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (up_ready) begin
        a_valid_r <= up_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      h_r <= h_nxt;
    end
    if (b_ready && a_valid_r) begin
      rad_r <= rad_nxt;
    end
  end

  assign dn_rad   = rad_r;
  assign dn_valid = b_valid_r;

endmodule
`default_nettype wire

/* design/chatan_deg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chatan_deg: degree conversion and output register
// Scales the heading in radians to Q9.6 degrees by a reciprocal multiply and
// holds both headings for the result channel.
// ----------------------------------------------------------------------------
module chatan_deg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [chatan_pkg::RAD_W-1:0]   up_rad,
  input  wire logic                           up_valid,
  output logic                                up_ready,
  output logic [chatan_pkg::RAD_W-1:0]        dn_rad,
  output logic [chatan_pkg::DEG_W-1:0]        dn_deg,
  output logic                                dn_valid,
  input  wire logic                           dn_ready
);
  import chatan_pkg::*;

  localparam int PROD_W = RAD_W + DEG_SHIFT;

  logic              valid_r;
  logic [RAD_W-1:0]  rad_r;
  logic [DEG_W-1:0]  deg_r;
  logic [PROD_W-1:0] prod;
  logic [DEG_W-1:0]  deg_nxt;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    prod    = PROD_W'(up_rad) * PROD_W'(DEG_MUL);
    deg_nxt = prod[DEG_SHIFT +: DEG_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rad_r <= up_rad;
      deg_r <= deg_nxt;
    end
  end

  assign dn_rad   = rad_r;
  assign dn_deg   = deg_r;
  assign dn_valid = valid_r;

endmodule
`default_nettype wire

/* design/compass_heading_atan2.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// compass_heading_atan2: magnetometer sample to compass heading
// Pipeline: one pre-rotation cell, one cell per micro-rotation, two wrap
//   cells and one degree/output cell.
// Throughput: one request per cycle; every cell holds its own item and stalls
//   only when the cells after it are full.
// Reset: clears all valid flags and loads the declination with 3957 (0.483 rad).
// ----------------------------------------------------------------------------
module compass_heading_atan2 #(
  parameter int CORDIC_STAGES = chatan_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [31:0]                   in_tdata,   // mag_x, mag_y
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [31:0]                        out_tdata,  // heading_rad, heading_deg, zero pad
  input  wire logic                          cfg_we,
  input  wire logic [chatan_pkg::DECL_W-1:0] cfg_wdata
);
  import chatan_pkg::*;

  logic signed [DECL_W-1:0] decl_r;
  cordic_t                  stg_data  [0:CORDIC_STAGES];
  logic                     stg_valid [0:CORDIC_STAGES];
  logic                     stg_ready [0:CORDIC_STAGES];
  logic [RAD_W-1:0]         wrap_rad;
  logic                     wrap_valid;
  logic                     wrap_ready;
  logic [RAD_W-1:0]         heading_rad;
  logic [DEG_W-1:0]         heading_deg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decl_r <= DECL_W'(DECL_RESET);
    end else if (cfg_we) begin
      decl_r <= cfg_wdata;
    end
  end

  chatan_prerot u_prerot (
    .clk      (clk),
    .rst_n    (rst_n),
    .mag_x    (in_tdata[15:0]),
    .mag_y    (in_tdata[31:16]),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .dn_data  (stg_data[0]),
    .dn_valid (stg_valid[0]),
    .dn_ready (stg_ready[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    chatan_cell #(
      .STAGE (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_data  (stg_data[i]),
      .up_valid (stg_valid[i]),
      .up_ready (stg_ready[i]),
      .dn_data  (stg_data[i+1]),
      .dn_valid (stg_valid[i+1]),
      .dn_ready (stg_ready[i+1])
    );
  end

  chatan_wrap u_wrap (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_data  (stg_data[CORDIC_STAGES]),
    .up_valid (stg_valid[CORDIC_STAGES]),
    .up_ready (stg_ready[CORDIC_STAGES]),
    .decl     (decl_r),
    .dn_rad   (wrap_rad),
    .dn_valid (wrap_valid),
    .dn_ready (wrap_ready)
  );

  chatan_deg u_deg (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_rad   (wrap_rad),
    .up_valid (wrap_valid),
    .up_ready (wrap_ready),
    .dn_rad   (heading_rad),
    .dn_deg   (heading_deg),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready)
  );

  assign out_tdata = {1'b0, heading_deg, heading_rad};

`ifndef SYNTH
  a_rad_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (heading_rad < RAD_W'(TWO_PI_Q13)))
    else $error("heading_rad out of range");

  a_deg_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (heading_deg < DEG_W'(23040)))
    else $error("heading_deg out of range");

  a_zero_heading : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (heading_rad == '0)) |-> (heading_deg == '0))
    else $error("zero radians must give zero degrees");

  a_stall_only_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while output side is free");
`endif

endmodule
`default_nettype wire
